/* rtl/s5scan_pkg.sv */
// Shared types and constants of the S5 sleep-type scanner.
// Used by the slot tracker and the scanner top level; no dependencies.
package s5scan_pkg;

  localparam logic [7:0] OpPackage    = 8'h12;
  localparam logic [7:0] OpBytePrefix = 8'h0A;
  localparam logic [7:0] OpZero       = 8'h00;
  localparam logic [7:0] OpOne        = 8'h01;
  localparam logic [7:0] OpOnes       = 8'hFF;
  localparam logic [7:0] ChUnder      = 8'h5F;
  localparam logic [7:0] ChS          = 8'h53;
  localparam logic [7:0] ChFive       = 8'h35;

  typedef struct packed {
    logic kill;
    logic start;
  } slot_ctrl_t;

  typedef struct packed {
    logic       busy;
    logic       free_next;
    logic       commit;
    logic [2:0] commit_val;
    logic       committed;
    logic       emit_req;
    logic [2:0] res_a;
    logic [2:0] res_b;
  } slot_stat_t;

  typedef struct packed {
    logic       s5_found;
    logic [2:0] sleep_type_a;
    logic [2:0] sleep_type_b;
  } result_t;

  function automatic logic is_short_int(input logic [7:0] x);
    return (x == OpZero) || (x == OpOne) || (x == OpOnes);
  endfunction

endpackage

/* rtl/s5scan_in_if.sv */
// Input channel of the S5 scanner: one body byte per beat with a last flag.
// Standalone valid/ready interface, no dependencies.
interface s5scan_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] body_byte;
  logic       final_byte;

  modport source (output valid, output body_byte, output final_byte, input ready);
  modport sink (input valid, input body_byte, input final_byte, output ready);
endinterface

/* rtl/s5scan_out_if.sv */
// Result channel of the S5 scanner: found flag and two sleep types per beat.
// Standalone valid/ready interface, no dependencies.
interface s5scan_out_if;
  logic       valid;
  logic       ready;
  logic       s5_found;
  logic [2:0] sleep_type_a;
  logic [2:0] sleep_type_b;

  modport source (output valid, output s5_found, output sleep_type_a,
                  output sleep_type_b, input ready);
  modport sink (input valid, input s5_found, input sleep_type_a,
                input sleep_type_b, output ready);
endinterface

/* rtl/s5scan_slot.sv */
// One candidate tracker: follows a "_S5_" match through the package header
// and its integers. Depends on s5scan_pkg.
module s5scan_slot (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    step_i,
  input  logic [7:0]              byte_i,
  input  logic                    fin_i,
  input  s5scan_pkg::slot_ctrl_t  ctrl_i,
  output s5scan_pkg::slot_stat_t  stat_o
);

  typedef enum logic [3:0] {
    PhIdle, PhPkg, PhLead, PhSkip, PhNumel, PhInt1, PhInt1b, PhInt2, PhInt2b
  } phase_e;

  phase_e     phase_q, phase_d;
  logic [1:0] skip_q, skip_d;
  logic [2:0] first_q, first_d;
  logic       short_x;

  assign short_x = s5scan_pkg::is_short_int(byte_i);

  always_comb begin
    phase_d = PhIdle;
    skip_d  = skip_q;
    first_d = first_q;
    stat_o  = '0;
    stat_o.busy  = (phase_q != PhIdle);
    stat_o.res_a = first_q;
    stat_o.commit_val = byte_i[2:0];
    unique case (phase_q)
      PhPkg:   phase_d = (byte_i == s5scan_pkg::OpPackage) ? PhLead : PhIdle;
      PhLead: begin
        skip_d  = byte_i[7:6];
        phase_d = (byte_i[7:6] != 2'd0) ? PhSkip : PhNumel;
      end
      PhSkip: begin
        skip_d  = skip_q - 2'd1;
        phase_d = (skip_q != 2'd1) ? PhSkip : PhNumel;
      end
      PhNumel: phase_d = PhInt1;
      PhInt1: begin
        if (short_x) begin
          first_d = byte_i[2:0];
          phase_d = PhInt2;
          stat_o.commit = 1'b1;
        end else if (byte_i == s5scan_pkg::OpBytePrefix) begin
          phase_d = PhInt1b;
        end
      end
      PhInt1b: begin
        first_d = byte_i[2:0];
        phase_d = PhInt2;
        stat_o.commit = 1'b1;
      end
      PhInt2: begin
        stat_o.committed = 1'b1;
        if (byte_i == s5scan_pkg::OpBytePrefix && !fin_i) begin
          phase_d = PhInt2b;
        end else begin
          stat_o.emit_req = 1'b1;
          stat_o.res_b = short_x ? byte_i[2:0] : 3'd0;
        end
      end
      PhInt2b: begin
        stat_o.committed = 1'b1;
        stat_o.emit_req  = 1'b1;
        stat_o.res_b     = byte_i[2:0];
      end
      default: phase_d = PhIdle;
    endcase
    stat_o.free_next = (phase_d == PhIdle);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhIdle;
      skip_q  <= 2'd0;
    end else if (step_i) begin
      if (ctrl_i.kill) begin
        phase_q <= PhIdle;
      end else if (ctrl_i.start) begin
        phase_q <= PhPkg;
        skip_q  <= 2'd0;
      end else begin
        phase_q <= phase_d;
        skip_q  <= skip_d;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      first_q <= 3'd0;
    end else if (step_i) begin
      first_q <= first_d;
    end
  end

endmodule

/* rtl/aml_s5_sleep_type_scanner.sv */
// S5 sleep-type scanner top level: byte history, candidate slots, result queue.
// A result is registered into the output entry behind out_o, or into the skid entry while out_o stalls.
// Throughput: one body byte per cycle while the skid entry is empty; in_i.ready drops while it holds a result.
// A two-entry result queue keeps input flowing while a result waits.
// Reset (rst_ni low, asynchronous) clears history, slots and queue; history and
// slots also return to reset after every final byte. Depends on s5scan_pkg, s5scan_slot.
module aml_s5_sleep_type_scanner #(
  parameter int ATTEMPTS = 4
) (
  input logic         clk_i,
  input logic         rst_ni,
  s5scan_in_if.sink   in_i,
  s5scan_out_if.source out_o
);

  localparam int IdxW = (ATTEMPTS > 1) ? $clog2(ATTEMPTS) : 1;

  s5scan_pkg::slot_ctrl_t ctrl [ATTEMPTS];
  s5scan_pkg::slot_stat_t stat [ATTEMPTS];

  logic [7:0] r1_q, r2_q, r3_q;
  logic [1:0] seen_q;
  logic       done_q;

  logic            accept, fin, pattern;
  logic [7:0]      x;
  logic            emit_any, commit_any, committed_any, free_any;
  logic [IdxW-1:0] emit_idx, commit_idx, free_idx;
  logic            push;
  s5scan_pkg::result_t res;

  s5scan_pkg::result_t out_q, skid_q;
  logic                out_valid_q, skid_valid_q;

  assign x      = in_i.body_byte;
  assign fin    = in_i.final_byte;
  assign accept = in_i.valid && in_i.ready;
  assign in_i.ready = !skid_valid_q;

  assign pattern = (seen_q == 2'd3) && (r1_q == s5scan_pkg::ChUnder) &&
                   (r2_q == s5scan_pkg::ChS) && (r3_q == s5scan_pkg::ChFive) &&
                   (x == s5scan_pkg::ChUnder);

  always_comb begin
    emit_any = 1'b0;
    commit_any = 1'b0;
    committed_any = 1'b0;
    free_any = 1'b0;
    emit_idx = '0;
    commit_idx = '0;
    free_idx = '0;
    for (int i = ATTEMPTS - 1; i >= 0; i--) begin
      if (stat[i].emit_req) begin
        emit_any = 1'b1;
        emit_idx = IdxW'(i);
      end
      if (stat[i].commit) begin
        commit_any = 1'b1;
        commit_idx = IdxW'(i);
      end
      if (stat[i].free_next) begin
        free_any = 1'b1;
        free_idx = IdxW'(i);
      end
      if (stat[i].committed) begin
        committed_any = 1'b1;
      end
    end
  end

  for (genvar g = 0; g < ATTEMPTS; g++) begin : g_slot
    assign ctrl[g].kill = fin || emit_any ||
                          (commit_any && (commit_idx != IdxW'(g)));
    assign ctrl[g].start = !done_q && !emit_any && !commit_any && !committed_any &&
                           pattern && free_any && (free_idx == IdxW'(g));
    s5scan_slot u_slot (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .step_i (accept),
      .byte_i (x),
      .fin_i  (fin),
      .ctrl_i (ctrl[g]),
      .stat_o (stat[g])
    );
  end

  always_comb begin
    res  = '0;
    push = 1'b0;
    if (!done_q) begin
      if (emit_any) begin
        push = 1'b1;
        res.s5_found = 1'b1;
        res.sleep_type_a = stat[emit_idx].res_a;
        res.sleep_type_b = stat[emit_idx].res_b;
      end else if (commit_any && fin) begin
        push = 1'b1;
        res.s5_found = 1'b1;
        res.sleep_type_a = stat[commit_idx].commit_val;
      end else if (fin) begin
        push = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      r1_q <= '0;
      r2_q <= '0;
      r3_q <= '0;
      seen_q <= 2'd0;
      done_q <= 1'b0;
    end else if (accept) begin
      if (fin) begin
        r1_q <= '0;
        r2_q <= '0;
        r3_q <= '0;
        seen_q <= 2'd0;
        done_q <= 1'b0;
      end else begin
        r1_q <= r2_q;
        r2_q <= r3_q;
        r3_q <= x;
        if (seen_q != 2'd3) begin
          seen_q <= seen_q + 2'd1;
        end
        if (emit_any) begin
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      skid_valid_q <= 1'b0;
      out_q <= '0;
      skid_q <= '0;
    end else if (out_valid_q && !out_o.ready) begin
      if (accept && push) begin
        skid_q <= res;
        skid_valid_q <= 1'b1;
      end
    end else if (skid_valid_q) begin
      out_q <= skid_q;
      out_valid_q <= 1'b1;
      skid_valid_q <= 1'b0;
    end else begin
      out_q <= res;
      out_valid_q <= accept && push;
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.s5_found     = out_q.s5_found;
  assign out_o.sleep_type_a = out_q.sleep_type_a;
  assign out_o.sleep_type_b = out_q.sleep_type_b;

  logic [ATTEMPTS-1:0] busy_vec;
  for (genvar g = 0; g < ATTEMPTS; g++) begin : g_busy
    assign busy_vec[g] = stat[g].busy;
  end

  a_skid_implies_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid entry held without output entry");

  a_done_slots_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> (busy_vec == '0))
    else $error("slot active after result emitted");

  a_commit_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && commit_any && !emit_any && !fin && !done_q) |=> $countones(busy_vec) == 1)
    else $error("more than one slot survives a commit");

  a_fin_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && fin) |=> (seen_q == 2'd0) && !done_q && (busy_vec == '0))
    else $error("state not cleared after final beat");

endmodule
